@@ rtl/core/dwpi_pkg.sv @@
// Shared types and constants of the dual wheel PI speed controller.
`timescale 1ns / 1ps

package dwpi_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS         = 3'd0,
		REG_SAMPLE_PERIOD  = 3'd1,
		REG_LEFT_KP        = 3'd2,
		REG_LEFT_KI        = 3'd3,
		REG_RIGHT_KP       = 3'd4,
		REG_RIGHT_KI       = 3'd5,
		REG_INTEGRAL_LIMIT = 3'd6
	} cfg_reg_t;

	// Reset value of the integral clamp, whole speed units.
	localparam logic [14:0] INTEGRAL_LIMIT_RESET = 15'd600;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic        [15:0] radius;
		logic        [15:0] sample_period;
		logic signed [15:0] left_kp;
		logic signed [15:0] left_ki;
		logic signed [15:0] right_kp;
		logic signed [15:0] right_ki;
		logic        [14:0] integral_limit;
	} cfg_t;

	// Shared multiplier geometry.
	localparam int MUL_W  = 26;
	localparam int PROD_W = 2 * MUL_W;

	// Datapath widths.
	localparam int SPEED_W = 21;
	localparam int ERR_W   = 25;
	localparam int INTEG_W = 26;
	localparam int SUM_W   = 42;
	localparam int QUOT_W  = 16;

	// Division by 100 as a multiplication by ceil(2^30 / 100); exact for
	// every magnitude below the saturation threshold.
	localparam int                DIV100_SHIFT = 30;
	localparam logic [MUL_W-1:0]  DIV100_RECIP = 26'd10737419;
	localparam logic [SUM_W-1:0]  DUTY_SAT_MAG = 42'd6553600;
	localparam int                DIV_IN_W     = 23;
	localparam logic [QUOT_W-1:0] DUTY_FULL    = 16'hFFFF;

endpackage

@@ rtl/core/dwpi_ifs.sv @@
// Valid/ready stream interfaces for the tick input and the duty result.
`timescale 1ns / 1ps

interface dwpi_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_omega;
	logic signed [15:0] right_omega;
	logic signed [15:0] left_target;
	logic signed [15:0] right_target;

	modport source (output valid, left_omega, right_omega, left_target, right_target,
		input ready);
	modport sink (input valid, left_omega, right_omega, left_target, right_target,
		output ready);
endinterface

interface dwpi_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] left_duty;
	logic        left_reverse;
	logic [15:0] right_duty;
	logic        right_reverse;

	modport source (output valid, left_duty, left_reverse, right_duty, right_reverse,
		input ready);
	modport sink (input valid, left_duty, left_reverse, right_duty, right_reverse,
		output ready);
endinterface

@@ rtl/core/dwpi_cfg.sv @@
// Configuration register file of the speed controller.
`timescale 1ns / 1ps

module dwpi_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dwpi_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dwpi_pkg::CFG_DATA_W-1:0] cfg_data,
	output dwpi_pkg::cfg_t                cfg
);

	dwpi_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius         <= '0;
			cfg_q.sample_period  <= '0;
			cfg_q.left_kp        <= '0;
			cfg_q.left_ki        <= '0;
			cfg_q.right_kp       <= '0;
			cfg_q.right_ki       <= '0;
			cfg_q.integral_limit <= dwpi_pkg::INTEGRAL_LIMIT_RESET;
		end else if (cfg_we) begin
			case (dwpi_pkg::cfg_reg_t'(cfg_idx))
				dwpi_pkg::REG_RADIUS:         cfg_q.radius         <= cfg_data;
				dwpi_pkg::REG_SAMPLE_PERIOD:  cfg_q.sample_period  <= cfg_data;
				dwpi_pkg::REG_LEFT_KP:        cfg_q.left_kp        <= $signed(cfg_data);
				dwpi_pkg::REG_LEFT_KI:        cfg_q.left_ki        <= $signed(cfg_data);
				dwpi_pkg::REG_RIGHT_KP:       cfg_q.right_kp       <= $signed(cfg_data);
				dwpi_pkg::REG_RIGHT_KI:       cfg_q.right_ki       <= $signed(cfg_data);
				dwpi_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/dwpi_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module dwpi_mul (
	input  logic                               clk,
	input  logic signed [dwpi_pkg::MUL_W-1:0]  a,
	input  logic signed [dwpi_pkg::MUL_W-1:0]  b,
	output logic signed [dwpi_pkg::PROD_W-1:0] p_q
);

	// One product per cycle, available in the following cycle.
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

@@ rtl/core/dwpi_seq.sv @@
// Sequencer and datapath that run both wheels through the shared multiplier.
`timescale 1ns / 1ps

module dwpi_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dwpi_pkg::cfg_t                     cfg,
	dwpi_in_if.sink                            in_ch,
	dwpi_out_if.source                         out_ch,
	output logic signed [dwpi_pkg::MUL_W-1:0]  mul_a,
	output logic signed [dwpi_pkg::MUL_W-1:0]  mul_b,
	input  logic signed [dwpi_pkg::PROD_W-1:0] mul_p
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_SPD  = 10'b0000000010,
		ST_ERR  = 10'b0000000100,
		ST_INTG = 10'b0000001000,
		ST_PROP = 10'b0000010000,
		ST_SUM  = 10'b0000100000,
		ST_ABS  = 10'b0001000000,
		ST_DIV  = 10'b0010000000,
		ST_QUOT = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	state_t st_q;
	logic   wheel_q;
	logic   out_valid_q;

	// Latched tick inputs.
	logic signed [15:0] l_omega_q, r_omega_q, l_target_q, r_target_q;

	// Per wheel integrals.
	logic signed [dwpi_pkg::INTEG_W-1:0] l_integ_q, r_integ_q;

	// Working registers.
	logic signed [dwpi_pkg::ERR_W-1:0]   err_q;
	logic signed [dwpi_pkg::INTEG_W-1:0] acc_q;
	logic signed [dwpi_pkg::SUM_W-1:0]   sum_q;
	logic        [dwpi_pkg::SUM_W-1:0]   mag_q;
	logic                                neg_q;
	logic                                sat_q;

	// Per wheel results and the output register.
	logic [15:0] l_duty_q, r_duty_q, out_l_duty_q, out_r_duty_q;
	logic        l_rev_q, r_rev_q, out_l_rev_q, out_r_rev_q;

	// Wheel selection.
	logic signed [15:0]                  omega_w, target_w, kp_w, ki_w;
	logic signed [dwpi_pkg::INTEG_W-1:0] integ_w;

	// Combinational datapath.
	logic signed [dwpi_pkg::SPEED_W-1:0] speed;
	logic signed [dwpi_pkg::ERR_W-1:0]   err_next;
	logic signed [dwpi_pkg::INTEG_W-1:0] inc;
	logic signed [dwpi_pkg::INTEG_W:0]   acc_sum;
	logic signed [dwpi_pkg::INTEG_W:0]   lim;
	logic signed [dwpi_pkg::INTEG_W:0]   acc_clamp;
	logic        [dwpi_pkg::QUOT_W-1:0]  quot;
	logic        [15:0]                  duty_next;
	logic                                out_load;

	assign omega_w  = wheel_q ? r_omega_q  : l_omega_q;
	assign target_w = wheel_q ? r_target_q : l_target_q;
	assign kp_w     = wheel_q ? cfg.right_kp : cfg.left_kp;
	assign ki_w     = wheel_q ? cfg.right_ki : cfg.left_ki;
	assign integ_w  = wheel_q ? r_integ_q  : l_integ_q;

	// Speed in Q.8 and the error against the target.
	assign speed    = mul_p[32:12];
	assign err_next = $signed({{4{speed[dwpi_pkg::SPEED_W-1]}}, speed})
		- $signed({target_w[15], target_w, 8'b0});

	// Integral step and clamp to the symmetric limit.
	assign inc     = mul_p[41:16];
	assign acc_sum = $signed({integ_w[dwpi_pkg::INTEG_W-1], integ_w})
		+ $signed({inc[dwpi_pkg::INTEG_W-1], inc});
	assign lim     = $signed({4'b0, cfg.integral_limit, 8'b0});

	always_comb begin
		if (acc_sum >= lim) begin
			acc_clamp = lim;
		end else if (acc_sum < -lim) begin
			acc_clamp = -lim;
		end else begin
			acc_clamp = acc_sum;
		end
	end

	// Quotient by 100 and saturation.
	assign quot      = mul_p[dwpi_pkg::DIV100_SHIFT +: dwpi_pkg::QUOT_W];
	assign duty_next = sat_q ? dwpi_pkg::DUTY_FULL : quot;

	// Operand selection for the shared multiplier.
	always_comb begin
		case (st_q)
			ST_SPD: begin
				mul_a = $signed({{10{omega_w[15]}}, omega_w});
				mul_b = $signed({10'b0, cfg.radius});
			end
			ST_ERR: begin
				mul_a = $signed({err_next[dwpi_pkg::ERR_W-1], err_next});
				mul_b = $signed({10'b0, cfg.sample_period});
			end
			ST_INTG: begin
				mul_a = $signed({err_q[dwpi_pkg::ERR_W-1], err_q});
				mul_b = $signed({{10{kp_w[15]}}, kp_w});
			end
			ST_PROP: begin
				mul_a = acc_q;
				mul_b = $signed({{10{ki_w[15]}}, ki_w});
			end
			ST_DIV: begin
				mul_a = $signed({3'b0, mag_q[dwpi_pkg::DIV_IN_W-1:0]});
				mul_b = $signed(dwpi_pkg::DIV100_RECIP);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign out_load = (st_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	// Sequencer and integral state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			wheel_q   <= 1'b0;
			l_integ_q <= '0;
			r_integ_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						st_q    <= ST_SPD;
						wheel_q <= 1'b0;
					end
				end
				ST_SPD:  st_q <= ST_ERR;
				ST_ERR:  st_q <= ST_INTG;
				ST_INTG: begin
					if (wheel_q) begin
						r_integ_q <= acc_clamp[dwpi_pkg::INTEG_W-1:0];
					end else begin
						l_integ_q <= acc_clamp[dwpi_pkg::INTEG_W-1:0];
					end
					st_q <= ST_PROP;
				end
				ST_PROP: st_q <= ST_SUM;
				ST_SUM:  st_q <= ST_ABS;
				ST_ABS:  st_q <= ST_DIV;
				ST_DIV:  st_q <= ST_QUOT;
				ST_QUOT: begin
					wheel_q <= ~wheel_q;
					st_q    <= wheel_q ? ST_DONE : ST_SPD;
				end
				ST_DONE: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_ch.valid) begin
			l_omega_q  <= in_ch.left_omega;
			r_omega_q  <= in_ch.right_omega;
			l_target_q <= in_ch.left_target;
			r_target_q <= in_ch.right_target;
		end
		case (st_q)
			ST_ERR:  err_q <= err_next;
			ST_INTG: acc_q <= acc_clamp[dwpi_pkg::INTEG_W-1:0];
			ST_PROP: sum_q <= mul_p[dwpi_pkg::SUM_W-1:0];
			ST_SUM:  sum_q <= sum_q + mul_p[dwpi_pkg::SUM_W-1:0];
			ST_ABS: begin
				neg_q <= sum_q[dwpi_pkg::SUM_W-1];
				mag_q <= sum_q[dwpi_pkg::SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
			end
			ST_DIV:  sat_q <= (mag_q >= dwpi_pkg::DUTY_SAT_MAG);
			ST_QUOT: begin
				if (wheel_q) begin
					r_duty_q <= duty_next;
					r_rev_q  <= neg_q;
				end else begin
					l_duty_q <= duty_next;
					l_rev_q  <= neg_q;
				end
			end
			default: ;
		endcase
	end

	// Output register: holds a finished beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_l_duty_q <= l_duty_q;
			out_l_rev_q  <= l_rev_q;
			out_r_duty_q <= r_duty_q;
			out_r_rev_q  <= r_rev_q;
		end
	end

	assign in_ch.ready          = (st_q == ST_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.left_duty     = out_l_duty_q;
	assign out_ch.left_reverse  = out_l_rev_q;
	assign out_ch.right_duty    = out_r_duty_q;
	assign out_ch.right_reverse = out_r_rev_q;

endmodule

@@ rtl/core/dual_wheel_pi_speed_controller.sv @@
// Top level of the dual wheel PI speed controller.
// An accepted input beat runs both wheels in turn, eight sequencer steps per
// wheel around the single shared multiplier, then a done step that loads the
// result into the output register once that register is free, and then idle.
// No new beat is taken until the result is loaded.
// Reset clears both integrals, the sequencer and the output valid, and loads
// the register reset values (integral limit 600, all others zero).
`timescale 1ns / 1ps

module dual_wheel_pi_speed_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	dwpi_in_if.sink                         in_ch,
	dwpi_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [dwpi_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dwpi_pkg::CFG_DATA_W-1:0] cfg_data
);

	dwpi_pkg::cfg_t                     cfg;
	logic signed [dwpi_pkg::MUL_W-1:0]  mul_a;
	logic signed [dwpi_pkg::MUL_W-1:0]  mul_b;
	logic signed [dwpi_pkg::PROD_W-1:0] mul_p;

	dwpi_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	dwpi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	dwpi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.mul_p  (mul_p)
	);

endmodule

@@ rtl/core/dwpi_checker.sv @@
// Port level checks of the speed controller and their binding.
`timescale 1ns / 1ps

module dwpi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [33:0] out_payload
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_payload))
		else $error("result payload changed while stalled");

	// The block is still busy at the last step of the first wheel of a tick.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##8 !in_ready)
		else $error("input taken while a tick is still in flight");

	// A new result appears only at the end of a tick, never from idle.
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result beat without a finished tick");

endmodule

bind dual_wheel_pi_speed_controller dwpi_checker u_dwpi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload ({out_ch.left_duty, out_ch.left_reverse,
		out_ch.right_duty, out_ch.right_reverse})
);
